@@ hw/rtl/esev_pkg.sv @@
// ----------------------------------------------------------------------------
// esev_pkg
// Shared constants, payload types and arithmetic helpers for the exponential
// strain energy evaluator.
// ----------------------------------------------------------------------------
package esev_pkg;

    // Configuration register indexes
    typedef logic [0:0] t_reg_idx;
    localparam t_reg_idx REG_ALPHA = 1'b0;
    localparam t_reg_idx REG_BETA  = 1'b1;

    // Fixed point constants
    localparam logic [63:0] ESEV_ONE24    = 64'd1 << 24;
    localparam logic [31:0] ESEV_ONE30    = 32'd1 << 30;
    localparam logic [47:0] ESEV_X_HIGH   = 48'd27 << 24;
    localparam logic [47:0] ESEV_X_LOW    = 48'd32 << 24;
    localparam logic [31:0] ESEV_LN2_Q32  = 32'd2977044472;
    localparam logic [63:0] ESEV_K_FULL   = (64'd1 << 56) / 64'd2977044472;
    localparam logic [24:0] ESEV_K_RECIP  = ESEV_K_FULL[24:0];
    localparam int          ESEV_TAYLOR_TERMS = 10;
    localparam int          ESEV_QW       = 48;
    localparam int          ESEV_DIV_STEP = 4;
    localparam logic [63:0] ESEV_BIG      = 64'd1 << 63;
    localparam logic [47:0] ESEV_POS_LIM  = (48'd1 << 47) - 48'd1;
    localparam logic [47:0] ESEV_NEG_LIM  = 48'd1 << 47;

    // Side data carried alongside the exp evaluation
    typedef struct packed {
        logic        r_neg;
        logic [47:0] brm;
        logic        ovf;
    } t_side;

    // Item through the Horner cells
    typedef struct packed {
        logic [29:0]       t30;
        logic [31:0]       p;
        logic signed [7:0] k;
        t_side             side;
    } t_hrn;

    // Finished derivatives and flags carried through the divider
    typedef struct packed {
        logic [47:0] df;
        logic [47:0] ddf;
        logic        ovf;
        logic        dz;
        logic        big;
        logic        neg;
    } t_res;

    // Item through the divider cells
    typedef struct packed {
        logic [31:0] rem;
        logic [47:0] q;
        logic [47:0] num;
        t_res        res;
    } t_div;

    typedef struct packed {
        logic        ovf;
        logic [47:0] val;
    } t_sat;

    // floor(a*b/2^16) from the two partial products; 2^63 once hi reaches 2^47
    function automatic logic [63:0] mul_q16(input logic [63:0] hi, input logic [63:0] lo);
        if (hi[63:47] != 17'd0) begin
            return ESEV_BIG;
        end
        return (hi << 16) + {16'd0, lo[63:16]};
    endfunction

    // Saturate a sign and magnitude to 48-bit two's complement
    function automatic t_sat sat_out(input logic neg, input logic [63:0] mag);
        t_sat s;
        s.ovf = 1'b0;
        if (!neg) begin
            if (mag > {16'd0, ESEV_POS_LIM}) begin
                s.val = ESEV_POS_LIM;
                s.ovf = 1'b1;
            end else begin
                s.val = mag[47:0];
            end
        end else begin
            if (mag > {16'd0, ESEV_NEG_LIM}) begin
                s.val = ESEV_NEG_LIM;
                s.ovf = 1'b1;
            end else begin
                s.val = 48'(64'd0 - mag);
            end
        end
        return s;
    endfunction

endpackage

@@ hw/rtl/esev_if.sv @@
// ----------------------------------------------------------------------------
// esev_if
// Valid/ready channels of the evaluator: input items, result items and
// register writes.
// ----------------------------------------------------------------------------
interface esev_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] stretch;

    modport source(output valid, output stretch, input ready);
    modport sink(input valid, input stretch, output ready);
endinterface

interface esev_out_if;
    logic               valid;
    logic               ready;
    logic signed [47:0] energy;
    logic signed [47:0] first_derivative;
    logic signed [47:0] second_derivative;
    logic               overflow;
    logic               divide_by_zero;

    modport source(output valid, output energy, output first_derivative,
                   output second_derivative, output overflow, output divide_by_zero,
                   input ready);
    modport sink(input valid, input energy, input first_derivative,
                 input second_derivative, input overflow, input divide_by_zero,
                 output ready);
endinterface

interface esev_cfg_if;
    logic        valid;
    logic        ready;
    logic [0:0]  index;
    logic [31:0] data;

    modport source(output valid, output index, output data, input ready);
    modport sink(input valid, input index, input data, output ready);
endinterface

@@ hw/rtl/esev_horner_cell.sv @@
// ----------------------------------------------------------------------------
// esev_horner_cell
// One Horner step of the Taylor exp: p' = 1 + floor(floor(t*p/2^30)/N),
// two register stages (multiply, then exact reciprocal division).
// ----------------------------------------------------------------------------
module esev_horner_cell
    import esev_pkg::*;
#(
    parameter int N = 1
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_vld,
    output logic o_rdy,
    input  t_hrn i_data,
    output logic o_vld,
    input  logic i_rdy,
    output t_hrn o_data
);

    // ceil(2^36/N) gives floor(m/N) exactly for m below 2^32
    localparam logic [63:0] RECIP_FULL = ((64'd1 << 36) + 64'(N) - 64'd1) / 64'(N);
    localparam logic [36:0] RECIP      = RECIP_FULL[36:0];

    logic        r_vld_a, r_vld_b;
    t_hrn        r_a, r_b;
    t_hrn        n_a, n_b;
    logic        w_en_a, w_en_b;
    logic [61:0] w_tp;
    logic [68:0] w_mq;

    assign w_en_b = !r_vld_b || i_rdy;
    assign w_en_a = !r_vld_a || w_en_b;
    assign o_rdy  = w_en_a;
    assign o_vld  = r_vld_b;
    assign o_data = r_b;

    // stage a: product t*p scaled back to Q.30
    always_comb begin
        w_tp  = 62'(i_data.t30) * 62'(i_data.p);
        n_a   = i_data;
        n_a.p = w_tp[61:30];
    end

    // stage b: divide by N and add one
    always_comb begin
        w_mq  = 69'(r_a.p) * 69'(RECIP);
        n_b   = r_a;
        n_b.p = 32'(33'(ESEV_ONE30) + w_mq[68:36]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_a <= 1'b0;
            r_vld_b <= 1'b0;
        end else begin
            if (w_en_a) r_vld_a <= i_vld;
            if (w_en_b) r_vld_b <= r_vld_a;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en_a) r_a <= n_a;
        if (w_en_b) r_b <= n_b;
    end

endmodule

@@ hw/rtl/esev_div_cell.sv @@
// ----------------------------------------------------------------------------
// esev_div_cell
// Restoring divider slice: STEPS quotient bits of numerator / beta per cell.
// ----------------------------------------------------------------------------
module esev_div_cell
    import esev_pkg::*;
#(
    parameter int STEPS = ESEV_DIV_STEP
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [31:0] i_beta,
    input  logic        i_vld,
    output logic        o_rdy,
    input  t_div        i_data,
    output logic        o_vld,
    input  logic        i_rdy,
    output t_div        o_data
);

    logic  r_vld;
    t_div  r_data;
    t_div  n_data;
    logic  w_en;

    assign w_en   = !r_vld || i_rdy;
    assign o_rdy  = w_en;
    assign o_vld  = r_vld;
    assign o_data = r_data;

    // shift in one numerator bit per step, subtract where it fits
    always_comb begin
        logic [32:0] rem2;
        n_data = i_data;
        rem2   = '0;
        for (int j = 0; j < STEPS; j++) begin
            rem2       = {n_data.rem, n_data.num[47]};
            n_data.num = {n_data.num[46:0], 1'b0};
            if (rem2 >= {1'b0, i_beta}) begin
                n_data.rem = 32'(rem2 - {1'b0, i_beta});
                n_data.q   = {n_data.q[46:0], 1'b1};
            end else begin
                n_data.rem = rem2[31:0];
                n_data.q   = {n_data.q[46:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (w_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) r_data <= n_data;
    end

endmodule

@@ hw/rtl/exp_strain_energy_eval_top.sv @@
// ----------------------------------------------------------------------------
// exp_strain_energy_eval_top
// Exponential strain energy evaluator: value, first and second derivative.
// ----------------------------------------------------------------------------
// Use: write alpha (index REG_ALPHA) and beta (index REG_BETA) through the
// register channel while no item is in flight; writes are always taken.
// Each input item carries one stretch invariant r (signed Q8.24). Each result
// item carries energy, first and second derivative (signed Q24.24, saturated)
// and the overflow and divide-by-zero flags.
// Path: registers s1 to s5 for argument and range reduction, the ten
// two-stage Horner cells, registers p1 to p5 for products and saturation,
// the divider cells with DIV_STEP quotient bits each (four by default) and
// one output register.
// Throughput: one item per cycle; every stage is its own register with a
// valid bit, so the input keeps being taken while any stage is empty.
// Reset clears alpha, beta and all valid bits; no items are in flight.
// When the receiver stalls, the pipeline fills stage by stage and the input
// ready drops only once every stage holds an item.
// ----------------------------------------------------------------------------
module exp_strain_energy_eval_top
    import esev_pkg::*;
#(
    parameter int DIV_STEP = ESEV_DIV_STEP
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    esev_in_if.sink           i_in,
    esev_cfg_if.sink          i_cfg,
    esev_out_if.source        o_out
);

    localparam int DIV_CELLS = ESEV_QW / DIV_STEP;

    // configuration registers
    logic [31:0] r_alpha, r_beta;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha <= '0;
            r_beta  <= '0;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_ALPHA: r_alpha <= i_cfg.data;
                REG_BETA:  r_beta  <= i_cfg.data;
                default:   ;
            endcase
        end
    end

    // ---------------------------------------------------------------- control
    logic r_s1_vld, r_s2_vld, r_s3_vld, r_s4_vld, r_s5_vld;
    logic r_p1_vld, r_p2_vld, r_p3_vld, r_p4_vld, r_p5_vld, r_f_vld;
    logic w_en_s1, w_en_s2, w_en_s3, w_en_s4, w_en_s5;
    logic w_en_p1, w_en_p2, w_en_p3, w_en_p4, w_en_p5, w_en_f;

    logic w_h_vld [0:ESEV_TAYLOR_TERMS];
    logic w_h_rdy [0:ESEV_TAYLOR_TERMS];
    t_hrn w_h_data[0:ESEV_TAYLOR_TERMS];
    logic w_d_vld [0:DIV_CELLS];
    logic w_d_rdy [0:DIV_CELLS];
    t_div w_d_data[0:DIV_CELLS];

    assign w_en_f  = !r_f_vld  || o_out.ready;
    assign w_d_rdy[DIV_CELLS] = w_en_f;
    assign w_en_p5 = !r_p5_vld || w_d_rdy[0];
    assign w_en_p4 = !r_p4_vld || w_en_p5;
    assign w_en_p3 = !r_p3_vld || w_en_p4;
    assign w_en_p2 = !r_p2_vld || w_en_p3;
    assign w_en_p1 = !r_p1_vld || w_en_p2;
    assign w_h_rdy[ESEV_TAYLOR_TERMS] = w_en_p1;
    assign w_en_s5 = !r_s5_vld || w_h_rdy[0];
    assign w_en_s4 = !r_s4_vld || w_en_s5;
    assign w_en_s3 = !r_s3_vld || w_en_s4;
    assign w_en_s2 = !r_s2_vld || w_en_s3;
    assign w_en_s1 = !r_s1_vld || w_en_s2;
    assign i_in.ready = w_en_s1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
            r_s4_vld <= 1'b0;
            r_s5_vld <= 1'b0;
            r_p1_vld <= 1'b0;
            r_p2_vld <= 1'b0;
            r_p3_vld <= 1'b0;
            r_p4_vld <= 1'b0;
            r_p5_vld <= 1'b0;
            r_f_vld  <= 1'b0;
        end else begin
            if (w_en_s1) r_s1_vld <= i_in.valid;
            if (w_en_s2) r_s2_vld <= r_s1_vld;
            if (w_en_s3) r_s3_vld <= r_s2_vld;
            if (w_en_s4) r_s4_vld <= r_s3_vld;
            if (w_en_s5) r_s5_vld <= r_s4_vld;
            if (w_en_p1) r_p1_vld <= w_h_vld[ESEV_TAYLOR_TERMS];
            if (w_en_p2) r_p2_vld <= r_p1_vld;
            if (w_en_p3) r_p3_vld <= r_p2_vld;
            if (w_en_p4) r_p4_vld <= r_p3_vld;
            if (w_en_p5) r_p5_vld <= r_p4_vld;
            if (w_en_f)  r_f_vld  <= w_d_vld[DIV_CELLS];
        end
    end

    // ------------------------------------------------- s1: beta*(r-1), beta*r
    logic [63:0] r_s1_xprod, r_s1_bprod, n_s1_xprod, n_s1_bprod;
    logic        r_s1_dneg, r_s1_rneg;
    logic signed [32:0] w_d, w_r;
    logic [31:0] w_dm, w_rm;

    always_comb begin
        w_r  = 33'(i_in.stretch);
        w_d  = w_r - 33'sd16777216;
        w_dm = w_d[32] ? 32'(-w_d) : w_d[31:0];
        w_rm = w_r[32] ? 32'(-w_r) : w_r[31:0];
        n_s1_xprod = 64'(w_dm) * 64'(r_beta);
        n_s1_bprod = 64'(w_rm) * 64'(r_beta);
    end

    always_ff @(posedge i_clk) begin
        if (w_en_s1) begin
            r_s1_xprod <= n_s1_xprod;
            r_s1_bprod <= n_s1_bprod;
            r_s1_dneg  <= w_d[32];
            r_s1_rneg  <= w_r[32];
        end
    end

    // ------------------------------------------------ s2: clamp exp argument
    logic signed [30:0] r_s2_x, n_s2_x;
    t_side r_s2_side, n_s2_side;
    logic [47:0] w_xm;

    always_comb begin
        w_xm = r_s1_xprod[63:16];
        n_s2_side.r_neg = r_s1_rneg;
        n_s2_side.brm   = r_s1_bprod[63:16];
        n_s2_side.ovf   = 1'b0;
        if (!r_s1_dneg && w_xm > ESEV_X_HIGH) begin
            n_s2_x        = 31'(ESEV_X_HIGH);
            n_s2_side.ovf = 1'b1;
        end else if (r_s1_dneg && w_xm > ESEV_X_LOW) begin
            n_s2_x = 31'(0) - 31'(ESEV_X_LOW);
        end else if (r_s1_dneg) begin
            n_s2_x = 31'(0) - w_xm[30:0];
        end else begin
            n_s2_x = w_xm[30:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en_s2) begin
            r_s2_x    <= n_s2_x;
            r_s2_side <= n_s2_side;
        end
    end

    // ---------------------------------------------- s3: x/ln2 by reciprocal
    logic signed [56:0] r_s3_xk, n_s3_xk;
    logic signed [30:0] r_s3_x;
    t_side r_s3_side;

    assign n_s3_xk = 57'(r_s2_x) * 57'($signed({1'b0, ESEV_K_RECIP}));

    always_ff @(posedge i_clk) begin
        if (w_en_s3) begin
            r_s3_xk   <= n_s3_xk;
            r_s3_x    <= r_s2_x;
            r_s3_side <= r_s2_side;
        end
    end

    // --------------------------------------------------- s4: k estimate * ln2
    logic signed [7:0]  w_kest, r_s4_k;
    logic signed [40:0] r_s4_kl, n_s4_kl;
    logic signed [30:0] r_s4_x;
    t_side r_s4_side;

    assign w_kest  = r_s3_xk[55:48];
    assign n_s4_kl = 41'(w_kest) * 41'($signed({1'b0, ESEV_LN2_Q32}));

    always_ff @(posedge i_clk) begin
        if (w_en_s4) begin
            r_s4_kl   <= n_s4_kl;
            r_s4_k    <= w_kest;
            r_s4_x    <= r_s3_x;
            r_s4_side <= r_s3_side;
        end
    end

    // --------------------------------------- s5: remainder t, fix k by one
    t_hrn r_s5_h, n_s5_h;
    logic signed [41:0] w_t, w_tc, w_ln2;

    always_comb begin
        w_ln2 = 42'($signed({1'b0, ESEV_LN2_Q32}));
        w_t   = (42'(r_s4_x) <<< 8) - 42'(r_s4_kl);
        n_s5_h.k = r_s4_k;
        if (w_t < 0) begin
            w_tc     = w_t + w_ln2;
            n_s5_h.k = r_s4_k - 8'sd1;
        end else if (w_t >= w_ln2) begin
            w_tc     = w_t - w_ln2;
            n_s5_h.k = r_s4_k + 8'sd1;
        end else begin
            w_tc = w_t;
        end
        n_s5_h.t30  = w_tc[31:2];
        n_s5_h.p    = ESEV_ONE30;
        n_s5_h.side = r_s4_side;
    end

    always_ff @(posedge i_clk) begin
        if (w_en_s5) r_s5_h <= n_s5_h;
    end

    // --------------------------------------------------------- Horner cells
    assign w_h_vld[0]  = r_s5_vld;
    assign w_h_data[0] = r_s5_h;

    for (genvar j = 0; j < ESEV_TAYLOR_TERMS; j++) begin : g_hrn
        esev_horner_cell #(
            .N(ESEV_TAYLOR_TERMS - j)
        ) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_vld  (w_h_vld[j]),
            .o_rdy  (w_h_rdy[j]),
            .i_data (w_h_data[j]),
            .o_vld  (w_h_vld[j+1]),
            .i_rdy  (w_h_rdy[j+1]),
            .o_data (w_h_data[j+1])
        );
    end

    // ------------------------------------------------ p1: e = p * 2^(k-6)
    t_hrn        w_hout;
    logic signed [7:0] w_sh;
    logic [7:0]  w_shn;
    logic [63:0] r_p1_e, n_p1_e;
    t_side       r_p1_side;

    always_comb begin
        w_hout = w_h_data[ESEV_TAYLOR_TERMS];
        w_sh   = w_hout.k - 8'sd6;
        w_shn  = 8'(8'sd0 - w_sh);
        if (w_sh >= 0) begin
            n_p1_e = 64'(w_hout.p) << w_sh[5:0];
        end else begin
            n_p1_e = 64'(w_hout.p) >> w_shn[5:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en_p1) begin
            r_p1_e    <= n_p1_e;
            r_p1_side <= w_hout.side;
        end
    end

    // ------------------------------- p2: alpha*e, operands of df and energy
    logic [63:0] r_p2_aeh, r_p2_ael, r_p2_g, r_p2_mag;
    logic [63:0] n_p2_g, n_p2_mag;
    logic        r_p2_dfneg, r_p2_eneg, r_p2_ovf, n_p2_eneg;
    logic [63:0] w_brm;

    always_comb begin
        w_brm = 64'(r_p1_side.brm);
        n_p2_g = (r_p1_e >= ESEV_ONE24) ? r_p1_e - ESEV_ONE24 : ESEV_ONE24 - r_p1_e;
        if (r_p1_side.r_neg) begin
            n_p2_mag  = r_p1_e + w_brm;
            n_p2_eneg = 1'b0;
        end else if (r_p1_e >= w_brm) begin
            n_p2_mag  = r_p1_e - w_brm;
            n_p2_eneg = 1'b0;
        end else begin
            n_p2_mag  = w_brm - r_p1_e;
            n_p2_eneg = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en_p2) begin
            r_p2_aeh   <= 64'(r_alpha) * 64'(r_p1_e[63:32]);
            r_p2_ael   <= 64'(r_alpha) * 64'(r_p1_e[31:0]);
            r_p2_g     <= n_p2_g;
            r_p2_dfneg <= (r_p1_e < ESEV_ONE24);
            r_p2_mag   <= n_p2_mag;
            r_p2_eneg  <= n_p2_eneg;
            r_p2_ovf   <= r_p1_side.ovf;
        end
    end

    // ---------------------------------- p3: alpha*g, alpha*mag partial products
    logic [63:0] r_p3_ae, r_p3_dfh, r_p3_dfl, r_p3_p0, r_p3_p1;
    logic        r_p3_dfneg, r_p3_eneg, r_p3_ovf;

    always_ff @(posedge i_clk) begin
        if (w_en_p3) begin
            r_p3_ae    <= mul_q16(r_p2_aeh, r_p2_ael);
            r_p3_dfh   <= 64'(r_alpha) * 64'(r_p2_g[63:32]);
            r_p3_dfl   <= 64'(r_alpha) * 64'(r_p2_g[31:0]);
            r_p3_p0    <= 64'(r_alpha) * 64'(r_p2_mag[31:0]);
            r_p3_p1    <= 64'(r_alpha) * 64'(r_p2_mag[63:32]);
            r_p3_dfneg <= r_p2_dfneg;
            r_p3_eneg  <= r_p2_eneg;
            r_p3_ovf   <= r_p2_ovf;
        end
    end

    // ------------------------------ p4: beta*alpha*e, df result, 96-bit product
    logic [63:0] r_p4_bh, r_p4_bl;
    logic [95:0] r_p4_prod;
    logic [47:0] r_p4_df;
    logic        r_p4_eneg, r_p4_ovf;
    t_sat        w_df_sat;

    assign w_df_sat = sat_out(r_p3_dfneg, mul_q16(r_p3_dfh, r_p3_dfl));

    always_ff @(posedge i_clk) begin
        if (w_en_p4) begin
            r_p4_bh   <= 64'(r_beta) * 64'(r_p3_ae[63:32]);
            r_p4_bl   <= 64'(r_beta) * 64'(r_p3_ae[31:0]);
            r_p4_prod <= 96'(r_p3_p0) + {r_p3_p1, 32'd0};
            r_p4_df   <= w_df_sat.val;
            r_p4_eneg <= r_p3_eneg;
            r_p4_ovf  <= r_p3_ovf | w_df_sat.ovf;
        end
    end

    // ----------------------------- p5: ddf result, divider set-up
    t_div r_p5_d, n_p5_d;
    t_sat w_ddf_sat;

    always_comb begin
        w_ddf_sat       = sat_out(1'b0, mul_q16(r_p4_bh, r_p4_bl));
        n_p5_d.rem      = r_p4_prod[79:48];
        n_p5_d.q        = '0;
        n_p5_d.num      = r_p4_prod[47:0];
        n_p5_d.res.df   = r_p4_df;
        n_p5_d.res.ddf  = w_ddf_sat.val;
        n_p5_d.res.ovf  = r_p4_ovf | w_ddf_sat.ovf;
        n_p5_d.res.dz   = (r_beta == 32'd0);
        n_p5_d.res.big  = (r_p4_prod[95:48] >= {16'd0, r_beta});
        n_p5_d.res.neg  = r_p4_eneg;
    end

    always_ff @(posedge i_clk) begin
        if (w_en_p5) r_p5_d <= n_p5_d;
    end

    // ---------------------------------------------------------- divider cells
    assign w_d_vld[0]  = r_p5_vld;
    assign w_d_data[0] = r_p5_d;

    for (genvar j = 0; j < DIV_CELLS; j++) begin : g_div
        esev_div_cell #(
            .STEPS(DIV_STEP)
        ) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_beta (r_beta),
            .i_vld  (w_d_vld[j]),
            .o_rdy  (w_d_rdy[j]),
            .i_data (w_d_data[j]),
            .o_vld  (w_d_vld[j+1]),
            .i_rdy  (w_d_rdy[j+1]),
            .o_data (w_d_data[j+1])
        );
    end

    // ------------------------------------------- output register: energy
    t_div        w_dout;
    t_sat        w_en_sat;
    logic [47:0] r_f_energy, r_f_df, r_f_ddf, n_f_energy;
    logic        r_f_ovf, r_f_dz, n_f_ovf;

    always_comb begin
        w_dout   = w_d_data[DIV_CELLS];
        w_en_sat = sat_out(w_dout.res.neg,
                           w_dout.res.big ? ESEV_BIG : {16'd0, w_dout.q});
        if (w_dout.res.dz) begin
            n_f_energy = ESEV_POS_LIM;
            n_f_ovf    = w_dout.res.ovf;
        end else begin
            n_f_energy = w_en_sat.val;
            n_f_ovf    = w_dout.res.ovf | w_en_sat.ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en_f) begin
            r_f_energy <= n_f_energy;
            r_f_df     <= w_dout.res.df;
            r_f_ddf    <= w_dout.res.ddf;
            r_f_ovf    <= n_f_ovf;
            r_f_dz     <= w_dout.res.dz;
        end
    end

    assign o_out.valid             = r_f_vld;
    assign o_out.energy            = $signed(r_f_energy);
    assign o_out.first_derivative  = $signed(r_f_df);
    assign o_out.second_derivative = $signed(r_f_ddf);
    assign o_out.overflow          = r_f_ovf;
    assign o_out.divide_by_zero    = r_f_dz;

endmodule
